// ===== hdl/fbba_pkg.sv =====
// Shared types and constants for the free block bitmap allocator.
// No dependencies; used by the controller, datapath, top level and checker.
package fbba_pkg;

  localparam int IDX_W   = 12;   // block index field width
  localparam int CMD_W   = 2;    // command field width
  localparam int WORD_W  = 64;   // bitmap word width
  localparam int BIT_W   = 6;    // bit position within a word

  localparam int NUM_ENTRIES_DEF    = 4096;
  localparam int RESERVED_COUNT_DEF = 25;

  // command codes
  localparam logic [CMD_W-1:0] CMD_FIND      = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MARK_USED = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MARK_FREE = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic latch_in;   // capture command and index
    logic scan_clr;   // word pointer back to zero
    logic scan_rd;    // read word at pointer, advance pointer
    logic init_wr;    // write reset word at pointer, advance pointer
    logic mark_rd;    // read word holding the latched index
    logic mark_wr;    // write back modified word
    logic emit_hit;   // result: free block found
    logic emit_miss;  // result: map full
    logic emit_echo;  // result: echo index
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic             addr_last;  // pointer at last word
    logic             hit;        // read word has a free bit
    logic             tag_last;   // read word is the last word
    logic             idx_ok;     // latched index is inside the map
    logic [CMD_W-1:0] cmd;        // latched command
  } sts_t;

endpackage

// ===== hdl/fbba_ctrl.sv =====
// Controller FSM of the free block bitmap allocator.
// Depends on fbba_pkg (ctl_t, sts_t, command codes).
module fbba_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [fbba_pkg::CMD_W-1:0] in_cmd,
  input  fbba_pkg::sts_t            sts,
  output fbba_pkg::ctl_t            ctl,
  output logic                      busy
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_FIND,
    S_MARK_RD,
    S_MARK_WR
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;
  logic   pend_r;   // scan read data valid this cycle

  always_comb begin
    ctl       = '0;
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        ctl.init_wr = 1'b1;
        if (sts.addr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          ctl.latch_in = 1'b1;
          ctl.scan_clr = 1'b1;
          state_nxt    = (in_cmd == fbba_pkg::CMD_FIND) ? S_FIND : S_MARK_RD;
        end
      end
      S_FIND: begin
        ctl.scan_rd = 1'b1;
        if (pend_r && sts.hit) begin
          ctl.emit_hit = 1'b1;
          state_nxt    = S_IDLE;
        end else if (pend_r && sts.tag_last) begin
          ctl.emit_miss = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_MARK_RD: begin
        ctl.mark_rd = 1'b1;
        state_nxt   = S_MARK_WR;
      end
      S_MARK_WR: begin
        ctl.mark_wr   = sts.idx_ok && ((sts.cmd == fbba_pkg::CMD_MARK_USED) ||
                                       (sts.cmd == fbba_pkg::CMD_MARK_FREE));
        ctl.emit_echo = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      busy_r  <= 1'b1;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
      pend_r  <= (state_r == S_FIND) && (state_nxt == S_FIND);
    end
  end

  assign busy = busy_r;

endmodule

// ===== hdl/fbba_dpath.sv =====
// Datapath of the free block bitmap allocator: bitmap memory, word pointer,
// first-free search and result registers. Depends on fbba_pkg.
module fbba_dpath #(
  parameter int NUM_ENTRIES    = fbba_pkg::NUM_ENTRIES_DEF,
  parameter int RESERVED_COUNT = fbba_pkg::RESERVED_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fbba_pkg::ctl_t              ctl,
  input  logic [fbba_pkg::CMD_W-1:0]  in_cmd,
  input  logic [fbba_pkg::IDX_W-1:0]  in_block_index,
  output fbba_pkg::sts_t              sts,
  output logic                        out_valid,
  output logic [fbba_pkg::IDX_W-1:0]  out_free_index,
  output logic                        out_found
);

  localparam int WW         = fbba_pkg::WORD_W;
  localparam int BW         = fbba_pkg::BIT_W;
  localparam int IW         = fbba_pkg::IDX_W;
  localparam int WORD_COUNT = (NUM_ENTRIES + WW - 1) / WW;
  localparam int WA_W       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int WIDE_W     = (IW > WA_W + BW) ? IW : WA_W + BW;
  localparam int RES_EFF    = (RESERVED_COUNT < NUM_ENTRIES) ? RESERVED_COUNT : NUM_ENTRIES;
  localparam int RES_WORDS  = RES_EFF / WW;
  localparam int RES_REM    = RES_EFF % WW;
  localparam int LAST_BITS  = NUM_ENTRIES - (WORD_COUNT - 1) * WW;
  localparam logic [WW-1:0] REM_MASK  = (64'd1 << RES_REM) - 64'd1;
  localparam logic [WW-1:0] LAST_MASK =
    (LAST_BITS == WW) ? {WW{1'b1}} : ((64'd1 << LAST_BITS) - 64'd1);
  localparam logic [WA_W-1:0] LAST_ADDR = WA_W'(WORD_COUNT - 1);

  logic [WW-1:0]              mem [WORD_COUNT];
  logic [WA_W-1:0]            addr_r;
  logic [WA_W-1:0]            tag_r;
  logic [WW-1:0]              rd_data_r;
  logic [fbba_pkg::CMD_W-1:0] cmd_r;
  logic [IW-1:0]              idx_r;
  logic                       out_valid_r;
  logic [IW-1:0]              out_free_index_r;
  logic                       out_found_r;

  logic [WIDE_W-1:0]          idx_wide;
  logic [WA_W-1:0]            idx_word;
  logic [WW-1:0]              bit_mask;
  logic [WW-1:0]              mod_word;
  logic [WW-1:0]              init_word;
  logic [WW-1:0]              free_bits;
  logic [BW-1:0]              pos;
  logic [WIDE_W-1:0]          hit_wide;
  logic                       we;
  logic [WA_W-1:0]            wa;
  logic [WW-1:0]              wd;
  logic                       re;
  logic [WA_W-1:0]            ra;

  assign idx_wide = WIDE_W'(idx_r);
  assign idx_word = idx_wide[BW +: WA_W];
  assign bit_mask = {{(WW-1){1'b0}}, 1'b1} << idx_r[BW-1:0];
  assign mod_word = (cmd_r == fbba_pkg::CMD_MARK_USED) ? (rd_data_r | bit_mask)
                                                       : (rd_data_r & ~bit_mask);

  // reset contents: reserved blocks marked used
  always_comb begin
    if (32'(addr_r) < RES_WORDS) begin
      init_word = {WW{1'b1}};
    end else if (32'(addr_r) == RES_WORDS) begin
      init_word = REM_MASK;
    end else begin
      init_word = '0;
    end
  end

  // free bits of the word just read; tail past the map never counts
  assign free_bits = ~rd_data_r & ((tag_r == LAST_ADDR) ? LAST_MASK : {WW{1'b1}});

  // lowest set bit
  always_comb begin
    pos = '0;
    for (int i = WW - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        pos = BW'(i);
      end
    end
  end

  assign hit_wide = WIDE_W'({tag_r, pos});

  assign we = ctl.init_wr || ctl.mark_wr;
  assign wa = ctl.init_wr ? addr_r : idx_word;
  assign wd = ctl.init_wr ? init_word : mod_word;
  assign re = ctl.scan_rd || ctl.mark_rd;
  assign ra = ctl.mark_rd ? idx_word : addr_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data_r <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.scan_clr) begin
        addr_r <= '0;
      end else if (ctl.scan_rd || ctl.init_wr) begin
        addr_r <= (addr_r == LAST_ADDR) ? '0 : addr_r + 1'b1;
      end
      out_valid_r <= ctl.emit_hit || ctl.emit_miss || ctl.emit_echo;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.scan_rd) begin
      tag_r <= addr_r;
    end
    if (ctl.latch_in) begin
      cmd_r <= in_cmd;
      idx_r <= in_block_index;
    end
    if (ctl.emit_hit) begin
      out_free_index_r <= hit_wide[IW-1:0];
      out_found_r      <= 1'b1;
    end else if (ctl.emit_miss) begin
      out_free_index_r <= '0;
      out_found_r      <= 1'b0;
    end else if (ctl.emit_echo) begin
      out_free_index_r <= idx_r;
      out_found_r      <= 1'b0;
    end
  end

  assign sts.addr_last = (addr_r == LAST_ADDR);
  assign sts.hit       = |free_bits;
  assign sts.tag_last  = (tag_r == LAST_ADDR);
  assign sts.idx_ok    = (32'(idx_r) < NUM_ENTRIES);
  assign sts.cmd       = cmd_r;

  assign out_valid      = out_valid_r;
  assign out_free_index = out_free_index_r;
  assign out_found      = out_found_r;

endmodule

// ===== hdl/free_block_bitmap_allocator.sv =====
// Top level of the free block bitmap allocator.
// Depends on fbba_pkg, fbba_ctrl and fbba_dpath.
//
// Usage:
//   Command channel: a transfer happens at a rising edge with start high and
//   busy low; in_cmd selects find (lowest free block), mark used or mark free,
//   in_block_index names the block to mark (ignored by find).
//   Result channel: out_valid is high for exactly one cycle per command and
//   carries out_free_index / out_found. The receiver cannot stall; a result
//   not taken in its cycle is gone.
//   Timing: a mark reads the word holding the block, then writes it back.
//   A find reads the map one 64-bit word per cycle through the
//   single memory read port, from word 0 up, and stops at the first word
//   with a free block or after the last word.
//   busy is low again in the cycle the result is shown, so the next command
//   can transfer at the edge that ends the result cycle.
//   Reset: rst_n is synchronous, active low. After reset the block sweeps
//   the bitmap memory word by word, writing blocks 0..RESERVED_COUNT-1 as
//   used and the rest as free; busy stays high during that sweep.
module free_block_bitmap_allocator #(
  parameter int NUM_ENTRIES    = fbba_pkg::NUM_ENTRIES_DEF,
  parameter int RESERVED_COUNT = fbba_pkg::RESERVED_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [fbba_pkg::CMD_W-1:0] in_cmd,
  input  logic [fbba_pkg::IDX_W-1:0] in_block_index,
  output logic                       out_valid,
  output logic [fbba_pkg::IDX_W-1:0] out_free_index,
  output logic                       out_found
);

  fbba_pkg::ctl_t ctl;   // FSM commands to the datapath
  fbba_pkg::sts_t sts;   // datapath status back to the FSM

  fbba_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .sts    (sts),
    .ctl    (ctl),
    .busy   (busy)
  );

  fbba_dpath #(
    .NUM_ENTRIES    (NUM_ENTRIES),
    .RESERVED_COUNT (RESERVED_COUNT)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .in_cmd         (in_cmd),
    .in_block_index (in_block_index),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_free_index (out_free_index),
    .out_found      (out_found)
  );

endmodule

// ===== hdl/fbba_chk.sv =====
// Port-level checker for the free block bitmap allocator, bound to the top.
// Depends on fbba_pkg for field widths.
module fbba_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic [fbba_pkg::CMD_W-1:0] in_cmd,
  input logic                       out_valid,
  input logic                       out_found
);

  // an accepted command raises busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  // a result only closes a command in flight
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) && !busy))
    else $error("result without a command in flight");

  // one result per command: never two strobes in a row
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // every non-find command yields a result, never with found
  a_mark_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_cmd != fbba_pkg::CMD_FIND)) |-> ##3 (out_valid && !out_found))
    else $error("mark command result missing or flagged found");

endmodule

bind free_block_bitmap_allocator fbba_chk u_fbba_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_cmd    (in_cmd),
  .out_valid (out_valid),
  .out_found (out_found)
);
